// ----- hw/rtl/gtc_pkg.sv -----
// Shared types and constants for the GOP timecode rewriter.
package gtc_pkg;

  localparam int BYTE_W  = 8;
  localparam int FNUM_W  = 31;
  localparam int RATE_W  = 16;
  localparam int DIV_W   = 40;
  localparam int DIV_CW  = $clog2(DIV_W + 1);
  localparam int HOLD_N  = 4;
  localparam int HOLD_IW = $clog2(HOLD_N);

  localparam int D60_STEPS  = DIV_W / BYTE_W;
  localparam int D60_CW     = $clog2(D60_STEPS + 1);
  localparam int RECIP60_SH = 20;

  localparam logic [31:0] GOP_START_CODE = 32'h0000_01B8;
  localparam logic [5:0]  SIXTY          = 6'd60;
  localparam logic [14:0] RECIP60        = 15'd17477;

  typedef enum logic [2:0] {
    ST_PASS,
    ST_DIV_RATE,
    ST_DIV_SEC,
    ST_DIV_MIN,
    ST_HOLD,
    ST_EMIT
  } gtc_state_t;

  typedef enum logic [1:0] {
    DIV_RATE,
    DIV_SEC,
    DIV_MIN
  } gtc_div_sel_t;

  typedef struct packed {
    logic         pass;
    logic         hold;
    logic         emit;
    logic         div_start;
    gtc_div_sel_t div_sel;
  } gtc_cmd_t;

  typedef struct packed {
    logic out_free;
    logic gop_hit;
    logic div_done;
    logic div_busy;
    logic hold_final;
    logic emit_final;
  } gtc_stat_t;

endpackage

// ----- hw/rtl/gtc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module gtc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gtc_pkg::DIV_W-1:0]   dividend,
  input  logic [gtc_pkg::RATE_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [gtc_pkg::DIV_W-1:0]   quot,
  output logic [gtc_pkg::RATE_W-1:0]  rem
);
  import gtc_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DIV_CW-1:0]   cnt_r, cnt_nxt;
  logic [DIV_W-1:0]    quot_r, quot_nxt;
  logic [RATE_W-1:0]   rem_r, rem_nxt;
  logic [RATE_W-1:0]   dsr_r, dsr_nxt;
  logic [RATE_W:0]     rem_sh;
  logic [RATE_W:0]     diff;
  logic                ge;

  assign rem_sh = {rem_r, quot_r[DIV_W-1]};
  assign ge     = (rem_sh >= {1'b0, dsr_r});
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CW'(DIV_W);
      quot_nxt = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quot_nxt = {quot_r[DIV_W-2:0], ge};
      rem_nxt  = ge ? diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// ----- hw/rtl/gtc_dp.sv -----
// Datapath: start code scan, timecode arithmetic, held bytes and output register.
module gtc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gtc_pkg::gtc_cmd_t           cmd,
  output gtc_pkg::gtc_stat_t          stat,
  input  logic [gtc_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        in_last,
  input  logic [gtc_pkg::FNUM_W-1:0]  frame_number,
  input  logic                        cfg_we,
  input  logic [gtc_pkg::RATE_W-1:0]  cfg_rate,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gtc_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last
);
  import gtc_pkg::*;

  logic [RATE_W-1:0]   rate_r;
  logic [31:0]         win_r;
  logic                gop_done_r;
  logic [HOLD_IW-1:0]  hold_cnt_r;
  logic [BYTE_W-1:0]   held_r [HOLD_N];
  logic [HOLD_IW-1:0]  emit_cnt_r;
  logic [HOLD_IW-1:0]  emit_idx_r;
  logic                emit_last_r;
  gtc_div_sel_t        sel_r;
  logic [5:0]          tc_fr_r, tc_sc_r, tc_mn_r;
  logic [4:0]          tc_hr_r;
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_last_r;
  logic                d60_busy_r;
  logic                d60_done_r;
  logic [D60_CW-1:0]   d60_cnt_r;
  logic [DIV_W-1:0]    d60_quot_r;
  logic [5:0]          d60_rem_r;

  logic [31:0]         win_nxt;
  logic [FNUM_W-1:0]   t_val;
  logic [DIV_W-1:0]    div_dividend;
  logic [RATE_W-1:0]   div_divisor;
  logic                rate_start;
  logic                rate_busy, rate_done;
  logic                div_busy, div_done;
  logic [DIV_W-1:0]    div_quot;
  logic [RATE_W-1:0]   div_rem;
  logic                d60_start;
  logic [DIV_W-1:0]    d60_dividend;
  logic [BYTE_W+5:0]   d60_part;
  logic [27:0]         d60_prod;
  logic [BYTE_W-1:0]   d60_digit;
  logic                old_zero;
  logic                patch;

  assign win_nxt = {win_r[23:0], in_byte};
  assign t_val   = frame_number - 1'b1;

  assign div_dividend = {1'b0, t_val, 8'h00};
  assign div_divisor  = (rate_r == '0) ? RATE_W'(1) : rate_r;
  assign rate_start   = cmd.div_start && (cmd.div_sel == DIV_RATE);
  assign d60_start    = cmd.div_start && (cmd.div_sel != DIV_RATE);
  assign d60_dividend = (cmd.div_sel == DIV_SEC) ? div_quot : d60_quot_r;

  gtc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rate_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (rate_busy),
    .done     (rate_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Division by sixty, one quotient byte per cycle by reciprocal multiplication.
  assign d60_part  = {d60_rem_r, d60_quot_r[DIV_W-1 -: BYTE_W]};
  assign d60_prod  = 28'(d60_part) * 28'(RECIP60);
  assign d60_digit = BYTE_W'(d60_prod >> RECIP60_SH);

  assign div_busy = rate_busy || d60_busy_r;
  assign div_done = rate_done || d60_done_r;

  assign old_zero = (held_r[0][6:2] == '0) && ({held_r[0][1:0], held_r[1][7:4]} == '0) &&
                    ({held_r[1][2:0], held_r[2][7:5]} == '0) &&
                    ({held_r[2][4:0], in_byte[7]} == '0);
  assign patch = (hold_cnt_r == HOLD_IW'(HOLD_N - 1)) && !old_zero;

  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.gop_hit    = !gop_done_r && !in_last && (win_nxt == GOP_START_CODE);
  assign stat.div_done   = div_done;
  assign stat.div_busy   = div_busy;
  assign stat.hold_final = in_last || (hold_cnt_r == HOLD_IW'(HOLD_N - 1));
  assign stat.emit_final = (emit_idx_r == emit_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= 16'd6400;
      win_r       <= '0;
      gop_done_r  <= 1'b0;
      hold_cnt_r  <= '0;
      emit_cnt_r  <= '0;
      emit_idx_r  <= '0;
      emit_last_r <= 1'b0;
      sel_r       <= DIV_RATE;
      out_valid_r <= 1'b0;
      d60_busy_r  <= 1'b0;
      d60_done_r  <= 1'b0;
      d60_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_rate;
      end
      if (cmd.div_start) begin
        sel_r <= cmd.div_sel;
      end
      d60_done_r <= d60_busy_r && !d60_start && (d60_cnt_r == D60_CW'(1));
      if (d60_start) begin
        d60_busy_r <= 1'b1;
        d60_cnt_r  <= D60_CW'(D60_STEPS);
      end else if (d60_busy_r) begin
        d60_cnt_r <= d60_cnt_r - 1'b1;
        if (d60_cnt_r == D60_CW'(1)) begin
          d60_busy_r <= 1'b0;
        end
      end
      if (cmd.pass) begin
        if (in_last) begin
          win_r      <= '0;
          gop_done_r <= 1'b0;
        end else if (!gop_done_r) begin
          win_r <= win_nxt;
          if (stat.gop_hit) begin
            gop_done_r <= 1'b1;
          end
        end
        hold_cnt_r <= '0;
      end
      if (cmd.hold) begin
        if (stat.hold_final) begin
          emit_cnt_r  <= hold_cnt_r;
          emit_idx_r  <= '0;
          emit_last_r <= in_last;
          hold_cnt_r  <= '0;
        end else begin
          hold_cnt_r <= hold_cnt_r + 1'b1;
        end
        if (in_last) begin
          win_r      <= '0;
          gop_done_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        emit_idx_r <= emit_idx_r + 1'b1;
      end
      if (cmd.pass || cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d60_start) begin
      d60_quot_r <= d60_dividend;
      d60_rem_r  <= '0;
    end else if (d60_busy_r) begin
      d60_quot_r <= {d60_quot_r[DIV_W-BYTE_W-1:0], d60_digit};
      d60_rem_r  <= d60_part[5:0] - 6'(d60_digit * SIXTY);
    end
    if (rate_done) begin
      tc_fr_r <= div_rem[13:8];
    end
    if (d60_done_r) begin
      unique case (sel_r)
        DIV_SEC: tc_sc_r <= d60_rem_r;
        DIV_MIN: begin
          tc_mn_r <= d60_rem_r;
          tc_hr_r <= d60_quot_r[4:0];
        end
        default: ;
      endcase
    end
    if (cmd.hold) begin
      if (patch) begin
        held_r[0] <= {held_r[0][7], tc_hr_r, tc_mn_r[5:4]};
        held_r[1] <= {tc_mn_r[3:0], held_r[1][3], tc_sc_r[5:3]};
        held_r[2] <= {tc_sc_r[2:0], tc_fr_r[5:1]};
        held_r[3] <= {tc_fr_r[0], in_byte[6:0]};
      end else begin
        held_r[hold_cnt_r] <= in_byte;
      end
    end
    if (cmd.pass) begin
      out_byte_r <= in_byte;
      out_last_r <= in_last;
    end else if (cmd.emit) begin
      out_byte_r <= held_r[emit_idx_r];
      out_last_r <= stat.emit_final && emit_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.pass) |-> stat.out_free)
    else $error("output register loaded while a beat is still waiting");

  a_gop_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pass && stat.gop_hit) |=> gop_done_r)
    else $error("start code found but not recorded");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hold && stat.hold_final) |=> (hold_cnt_r == '0) && (emit_idx_r == '0))
    else $error("hold count not cleared after the last timecode beat");

  a_sixty_rem: assert property (@(posedge clk) disable iff (!rst_n)
    d60_done_r |-> (d60_rem_r < SIXTY))
    else $error("remainder of the division by sixty out of range");

endmodule

// ----- hw/rtl/gtc_ctrl.sv -----
// Controller state machine sequencing scan, division, hold and emit phases.
module gtc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gtc_pkg::gtc_stat_t  stat,
  output gtc_pkg::gtc_cmd_t   cmd
);
  import gtc_pkg::*;

  gtc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PASS;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.pass      = 1'b0;
    cmd.hold      = 1'b0;
    cmd.emit      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = DIV_RATE;
    unique case (state_r)
      ST_PASS: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.pass = 1'b1;
          if (stat.gop_hit) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_RATE;
            state_nxt     = ST_DIV_RATE;
          end
        end
      end
      ST_DIV_RATE: begin
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEC;
          state_nxt     = ST_DIV_SEC;
        end
      end
      ST_DIV_SEC: begin
        cmd.div_sel = DIV_MIN;
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_MIN;
        end
      end
      ST_DIV_MIN: begin
        if (stat.div_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.hold = 1'b1;
          if (stat.hold_final) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_final) begin
            state_nxt = ST_PASS;
          end
        end
      end
      default: state_nxt = ST_PASS;
    endcase
  end

endmodule

// ----- hw/rtl/mpeg_gop_timecode_rewrite.sv -----
// Top level of the MPEG GOP header timecode rewriter.
//
//  Channel  Direction  Beat contents
//  in_      slave      in_tdata: in_byte[7:0], frame_number[38:8]; in_tlast
//  out_     master     out_tdata: out_byte[7:0]; out_tlast
//  cfg_     slave      cfg_data: frame_rate_q8[15:0]
//
// A byte outside the timecode passes through the output register whenever it is free.
// A start code stalls the input through the rate division and both divisions by sixty.
// Up to four timecode beats are held, then leave one by one through the output register.
// Reset is synchronous; the rate returns to 25 frames per second.
// Output stalls hold the input back through the single output register.
module mpeg_gop_timecode_rewrite (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // in_byte[7:0], frame_number[38:8], zero[39]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import gtc_pkg::*;

  gtc_cmd_t  cmd;
  gtc_stat_t stat;

  assign cfg_ready = 1'b1;

  gtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gtc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_byte      (in_tdata[7:0]),
    .in_last      (in_tlast),
    .frame_number (in_tdata[38:8]),
    .cfg_we       (cfg_valid),
    .cfg_rate     (cfg_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_tdata),
    .out_last     (out_tlast)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the MPEG GOP header timecode rewriter.
`timescale 1ns / 1ps

module testbench;
  import gtc_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD_OFF = 400;
  localparam int IDLE_PERCENT  = 24;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [FNUM_W-1:0] fnum;
  } byte_beat_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_beat_t;

  typedef enum int {
    BUF_GOP,
    BUF_TWO_CODES,
    BUF_ZERO_TC,
    BUF_CUT,
    BUF_CODE_LAST,
    BUF_NOISE
  } buf_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // in_byte[7:0], frame_number[38:8], zero[39]
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // out_byte[7:0]
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  byte_beat_t  pending_bytes[$];
  out_beat_t   expected_bytes[$];
  byte_beat_t  offered;
  int          errors = 0;
  logic        calm = 1'b0;
  int          hold_off_request = 0;
  int          hold_off_left = 0;

  // Predictor state.
  logic [RATE_W-1:0] rate_q8 = 16'd6400;
  logic [31:0]       scan_window = '0;
  logic [2:0]        tc_hold = '0;
  logic [7:0]        tc_kept[3];
  logic              gop_seen = 1'b0;
  logic [22:0]       gop_timecode = '0;

  mpeg_gop_timecode_rewrite dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [22:0] frame_timecode(input logic [FNUM_W-1:0] fnum);
    logic [FNUM_W-1:0] elapsed;
    logic [63:0]       divisor;
    logic [63:0]       scaled;
    logic [63:0]       secs;
    logic [63:0]       frac;
    logic [63:0]       hours;
    logic [63:0]       mins;
    logic [63:0]       rem_secs;
    elapsed  = fnum - 31'd1;
    divisor  = (rate_q8 == '0) ? 64'd1 : {48'd0, rate_q8};
    scaled   = {25'd0, elapsed, 8'd0};
    secs     = scaled / divisor;
    frac     = scaled - secs * divisor;
    hours    = secs / 3600;
    mins     = (secs / 60) % 60;
    rem_secs = secs % 60;
    return {hours[4:0], mins[5:0], rem_secs[5:0], frac[13:8]};
  endfunction

  task automatic expect_byte(input logic [7:0] data, input logic last);
    out_beat_t e;
    e.data = data;
    e.last = last;
    expected_bytes.push_back(e);
  endtask

  task automatic end_buffer();
    scan_window = '0;
    gop_seen    = 1'b0;
    tc_hold     = '0;
  endtask

  task automatic predict_rewrite(input byte_beat_t b);
    logic [7:0] b0, b1, b2, b3;
    logic [4:0] hr;
    logic [5:0] mn, sc, fr;
    logic       old_zero;
    if (tc_hold >= 3'd1 && tc_hold <= 3'd3) begin
      if (b.last) begin
        for (int k = 0; k < int'(tc_hold) - 1; k++) expect_byte(tc_kept[k], 1'b0);
        expect_byte(b.data, 1'b1);
        end_buffer();
      end else begin
        tc_kept[tc_hold - 3'd1] = b.data;
        tc_hold = tc_hold + 3'd1;
      end
    end else if (tc_hold == 3'd4) begin
      b0 = tc_kept[0];
      b1 = tc_kept[1];
      b2 = tc_kept[2];
      b3 = b.data;
      old_zero = (b0[6:0] == '0) && (b1[7:4] == '0) && (b1[2:0] == '0) &&
                 (b2 == '0) && !b3[7];
      if (!old_zero) begin
        {hr, mn, sc, fr} = gop_timecode;
        b0 = (b0 & 8'h80) | {1'b0, hr, mn[5:4]};
        b1 = (b1 & 8'h08) | {mn[3:0], 1'b0, sc[5:3]};
        b2 = {sc[2:0], fr[5:1]};
        b3 = (b3 & 8'h7F) | {fr[0], 7'd0};
      end
      expect_byte(b0, 1'b0);
      expect_byte(b1, 1'b0);
      expect_byte(b2, 1'b0);
      expect_byte(b3, b.last);
      tc_hold = '0;
      if (b.last) end_buffer();
    end else begin
      tc_hold = '0;
      expect_byte(b.data, b.last);
      if (!gop_seen) begin
        scan_window = {scan_window[23:0], b.data};
        if (scan_window == GOP_START_CODE) begin
          gop_seen     = 1'b1;
          gop_timecode = frame_timecode(b.fnum);
          tc_hold      = 3'd1;
        end
      end
      if (b.last) end_buffer();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_rewrite(offered);
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
          offered = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, offered.fnum, offered.data};
          in_tlast  <= offered.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_beat_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual byte %h last %b",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          e = expected_bytes.pop_front();
          if (out_tdata !== e.data) begin
            $display("%0t: out_byte mismatch, expected %h, actual %h",
                     $time, e.data, out_tdata);
            errors++;
          end
          if (out_tlast !== e.last) begin
            $display("%0t: out_last mismatch, expected %b, actual %b",
                     $time, e.last, out_tlast);
            errors++;
          end
        end
      end
      if (hold_off_request != 0) begin
        hold_off_left    = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_off_left != 0) begin
        hold_off_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || $urandom_range(99) >= IDLE_PERCENT;
      end
    end
  end

  task automatic push_beat(input logic [7:0] data, input logic last,
                           input logic [FNUM_W-1:0] fnum);
    byte_beat_t b;
    b.data = data;
    b.last = last;
    b.fnum = fnum;
    pending_bytes.push_back(b);
  endtask

  function automatic logic [7:0] scan_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'hB8;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [FNUM_W-1:0] random_fnum();
    case ($urandom_range(3))
      0:       return 31'($urandom_range(1, 3000));
      1:       return 31'($urandom);
      2:       return 31'h7FFF_FFFF - 31'($urandom_range(0, 100));
      default: return 31'($urandom_range(1, 2000000));
    endcase
  endfunction

  task automatic queue_buffer(input buf_kind_t kind, output int count);
    logic [7:0]        bytes[$];
    logic [FNUM_W-1:0] fnum;
    int                n;
    fnum = random_fnum();
    if (kind == BUF_NOISE) begin
      n = $urandom_range(1, 12);
      repeat (n) bytes.push_back(scan_byte());
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) bytes.push_back(scan_byte());
      bytes.push_back(8'h00);
      bytes.push_back(8'h00);
      bytes.push_back(8'h01);
      bytes.push_back(8'hB8);
      if (kind == BUF_CUT) begin
        n = $urandom_range(1, 3);
        repeat (n) bytes.push_back(8'($urandom));
      end else if (kind != BUF_CODE_LAST) begin
        if (kind == BUF_ZERO_TC) begin
          bytes.push_back(8'($urandom) & 8'h80);
          bytes.push_back(8'($urandom) & 8'h08);
          bytes.push_back(8'h00);
          bytes.push_back(8'($urandom) & 8'h7F);
        end else begin
          repeat (4) bytes.push_back(8'($urandom));
        end
        if (kind == BUF_TWO_CODES) begin
          bytes.push_back(8'h00);
          bytes.push_back(8'h00);
          bytes.push_back(8'h01);
          bytes.push_back(8'hB8);
          repeat (4) bytes.push_back(8'($urandom));
        end
        n = $urandom_range(0, 3);
        repeat (n) bytes.push_back(scan_byte());
      end
    end
    foreach (bytes[i]) push_beat(bytes[i], i == bytes.size() - 1, fnum);
    count = bytes.size();
  endtask

  function automatic buf_kind_t pick_kind();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return BUF_GOP;
    if (roll < 70) return BUF_TWO_CODES;
    if (roll < 78) return BUF_ZERO_TC;
    if (roll < 86) return BUF_CUT;
    if (roll < 92) return BUF_CODE_LAST;
    return BUF_NOISE;
  endfunction

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_tvalid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rate_q8 = value;
  endtask

  initial begin
    logic [RATE_W-1:0] rates[7];
    int                queued;
    int                n;
    rates = '{16'd1, 16'd65535, 16'd7672, 16'd0, 16'd15360, 16'd6400, 16'd6400};
    rates[6] = 16'($urandom_range(1, 65535));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Rewritten timecode at the highest frame number, last on the fourth timecode byte.
    push_beat(8'h00, 1'b0, 31'h7FFF_FFFF);
    push_beat(8'h00, 1'b0, 31'h7FFF_FFFF);
    push_beat(8'h01, 1'b0, 31'h7FFF_FFFF);
    push_beat(8'hB8, 1'b0, 31'h7FFF_FFFF);
    push_beat(8'hFF, 1'b0, 31'h7FFF_FFFF);
    push_beat(8'h5A, 1'b0, 31'h7FFF_FFFF);
    push_beat(8'hC3, 1'b0, 31'h7FFF_FFFF);
    push_beat(8'h3C, 1'b1, 31'h7FFF_FFFF);
    // An all-zero old timecode with the flag bits set passes unchanged.
    push_beat(8'h00, 1'b0, 31'd1);
    push_beat(8'h00, 1'b0, 31'd1);
    push_beat(8'h01, 1'b0, 31'd1);
    push_beat(8'hB8, 1'b0, 31'd1);
    push_beat(8'h80, 1'b0, 31'd1);
    push_beat(8'h08, 1'b0, 31'd1);
    push_beat(8'h00, 1'b0, 31'd1);
    push_beat(8'h7F, 1'b1, 31'd1);
    // A start code on the last byte, with frame number zero.
    push_beat(8'h00, 1'b0, 31'd0);
    push_beat(8'h00, 1'b0, 31'd0);
    push_beat(8'h01, 1'b0, 31'd0);
    push_beat(8'hB8, 1'b1, 31'd0);
    // The buffer ends inside the timecode.
    push_beat(8'h00, 1'b0, 31'd12345);
    push_beat(8'h00, 1'b0, 31'd12345);
    push_beat(8'h01, 1'b0, 31'd12345);
    push_beat(8'hB8, 1'b0, 31'd12345);
    push_beat(8'h11, 1'b0, 31'd12345);
    push_beat(8'h22, 1'b1, 31'd12345);
    wait_idle();

    foreach (rates[p]) begin
      write_rate(rates[p]);
      calm = (p == 4);
      queued = 0;
      if (p == 2) begin
        hold_off_request = LONG_HOLD_OFF;
        n = $urandom_range(20, 26);
        for (int i = 0; i < n; i++) push_beat(8'($urandom), i == n - 1, random_fnum());
        queue_buffer(BUF_GOP, n);
        queued = n;
      end
      while (queued < 8) begin
        queue_buffer(pick_kind(), n);
        queued += n;
      end
      wait_idle();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
